// File: rtl/ehw_pkg.sv
// Package for the IPv6 extension header walker.
// Holds header type codes, length constants and the walk state type.
// No dependencies.
`default_nettype none

package ehw_pkg;

    localparam int MAX_CHAIN_DEFAULT = 6;

    localparam int TYPE_W   = 8;
    localparam int L3_W     = 12;
    localparam int OFFSET_W = 15;
    localparam int MASK_W   = 6;
    localparam int COUNT_W  = 3;
    localparam int HDRLEN_W = 12;

    localparam logic [TYPE_W-1:0] T_HOP      = 8'd0;
    localparam logic [TYPE_W-1:0] T_ROUTING  = 8'd43;
    localparam logic [TYPE_W-1:0] T_FRAGMENT = 8'd44;
    localparam logic [TYPE_W-1:0] T_AH       = 8'd51;
    localparam logic [TYPE_W-1:0] T_DSTOPTS  = 8'd60;
    localparam logic [TYPE_W-1:0] T_MOBILITY = 8'd135;

    localparam logic [HDRLEN_W-1:0] OPT_LEN_BIAS   = 12'd1;
    localparam int                  OPT_LEN_SHAMT  = 3;
    localparam logic [HDRLEN_W-1:0] AH_LEN_BIAS    = 12'd2;
    localparam int                  AH_LEN_SHAMT   = 2;
    localparam logic [HDRLEN_W-1:0] EH_FRAG_BYTES  = 12'd8;
    localparam logic [OFFSET_W-1:0] IPV6_FIXED_LEN = 15'd40;

    typedef struct packed {
        logic                finished;
        logic [TYPE_W-1:0]   cur_type;
        logic [OFFSET_W-1:0] offset;
        logic [MASK_W-1:0]   mask;
        logic [COUNT_W-1:0]  count;
    } t_ehw_state;

endpackage

`default_nettype wire

// File: rtl/ehw_ifs.sv
// Handshake interfaces for the walker's item and result channels.
// Depends on ehw_pkg for field widths.
`default_nettype none

interface ehw_item_if
    import ehw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [TYPE_W-1:0] base_next_header;
    logic [L3_W-1:0]   ip_hdr_offset;
    logic              ext_valid;
    logic [TYPE_W-1:0] ext_next_header;
    logic [7:0]        ext_length;

    modport source (output valid, start_req, base_next_header, ip_hdr_offset, ext_valid,
                    ext_next_header, ext_length, input ready);
    modport sink (input valid, start_req, base_next_header, ip_hdr_offset, ext_valid,
                  ext_next_header, ext_length, output ready);
endinterface

interface ehw_result_if
    import ehw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                done_res;
    logic [TYPE_W-1:0]   protocol;
    logic [OFFSET_W-1:0] payload_offset;
    logic [MASK_W-1:0]   eh_mask;

    modport source (output valid, done_res, protocol, payload_offset, eh_mask, input ready);
    modport sink (input valid, done_res, protocol, payload_offset, eh_mask, output ready);
endinterface

`default_nettype wire

// File: rtl/ehw_step.sv
// One step of the extension header walk: next walk state from the current
// state and one item. Depends on ehw_pkg.
`default_nettype none

module ehw_step
    import ehw_pkg::*;
#(
    parameter int MAX_CHAIN = MAX_CHAIN_DEFAULT
) (
    input  t_ehw_state        i_state,
    input  logic              i_start_req,
    input  logic [TYPE_W-1:0] i_base_next_header,
    input  logic [L3_W-1:0]   i_ip_hdr_offset,
    input  logic              i_ext_valid,
    input  logic [TYPE_W-1:0] i_ext_next_header,
    input  logic [7:0]        i_ext_length,
    output t_ehw_state        o_state
);

    logic [MASK_W-1:0]   type_bit;
    logic [HDRLEN_W-1:0] len_ext;
    logic [HDRLEN_W-1:0] hdr_bytes;
    logic [COUNT_W:0]    count_inc;

    always_comb begin
        case (i_state.cur_type)
            T_HOP:      type_bit = 6'b000001;
            T_ROUTING:  type_bit = 6'b000010;
            T_FRAGMENT: type_bit = 6'b000100;
            T_AH:       type_bit = 6'b001000;
            T_DSTOPTS:  type_bit = 6'b010000;
            T_MOBILITY: type_bit = 6'b100000;
            default:    type_bit = 6'b000000;
        endcase
    end

    assign len_ext = {4'b0, i_ext_length};

    always_comb begin
        case (i_state.cur_type)
            T_AH:       hdr_bytes = (len_ext + AH_LEN_BIAS) << AH_LEN_SHAMT;
            T_FRAGMENT: hdr_bytes = EH_FRAG_BYTES;
            default:    hdr_bytes = (len_ext + OPT_LEN_BIAS) << OPT_LEN_SHAMT;
        endcase
    end

    assign count_inc = {1'b0, i_state.count} + 1'b1;

    always_comb begin
        o_state = i_state;
        if (i_start_req) begin
            o_state.cur_type = i_base_next_header;
            o_state.offset   = {{(OFFSET_W-L3_W){1'b0}}, i_ip_hdr_offset} + IPV6_FIXED_LEN;
            o_state.mask     = '0;
            o_state.count    = '0;
            o_state.finished = 1'b0;
        end else if (!i_state.finished) begin
            if (!i_ext_valid || type_bit == '0) begin
                o_state.finished = 1'b1;
            end else begin
                o_state.mask     = i_state.mask | type_bit;
                o_state.offset   = i_state.offset + {{(OFFSET_W-HDRLEN_W){1'b0}}, hdr_bytes};
                o_state.cur_type = i_ext_next_header;
                o_state.count    = count_inc[COUNT_W-1:0];
                o_state.finished = (count_inc >= (COUNT_W+1)'(MAX_CHAIN));
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/ipv6_extension_header_walker_unit.sv
// Top level of the IPv6 extension header walker.
// Depends on ehw_pkg, the channel interfaces and ehw_step.
`default_nettype none

// Each accepted item advances the walk by at most one header and yields exactly
// one result, which is loaded into the result register when the item is accepted.
// The block takes one item per cycle; the only limit is the result register,
// which must be free or being taken in the same cycle for a new item to enter.
// The walk state and the result register are the same flops, so a result
// shows the state left by its item. A start item loads a new walk; items
// that arrive after the walk ends repeat the final result with done_res set.
module ipv6_extension_header_walker_unit
    import ehw_pkg::*;
#(
    parameter int MAX_CHAIN = MAX_CHAIN_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ehw_item_if.sink        i_item,
    ehw_result_if.source    o_result
);

    t_ehw_state r_state;
    t_ehw_state n_state;
    logic       r_out_valid;
    logic       item_acc;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign item_acc     = i_item.valid && i_item.ready;

    ehw_step #(
        .MAX_CHAIN(MAX_CHAIN)
    ) u_step (
        .i_state           (r_state),
        .i_start_req       (i_item.start_req),
        .i_base_next_header(i_item.base_next_header),
        .i_ip_hdr_offset   (i_item.ip_hdr_offset),
        .i_ext_valid       (i_item.ext_valid),
        .i_ext_next_header (i_item.ext_next_header),
        .i_ext_length      (i_item.ext_length),
        .o_state           (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= t_ehw_state'{finished: 1'b1, cur_type: '0, offset: '0,
                                        mask: '0, count: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (item_acc) begin
                r_state <= n_state;
            end
            if (item_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.done_res       = r_state.finished;
    assign o_result.protocol       = r_state.cur_type;
    assign o_result.payload_offset = r_state.offset;
    assign o_result.eh_mask        = r_state.mask;

`ifndef SYNTHESIS
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_acc |=> o_result.valid)
        else $error("Accepted item did not produce a result.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_state.count} <= (COUNT_W+1)'(MAX_CHAIN))
        else $error("Header count exceeded the chain limit.");

    a_start_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && i_item.start_req) |=> !o_result.done_res)
        else $error("Start item reported a finished walk.");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && !i_item.start_req && r_state.finished) |=> $stable(r_state))
        else $error("Walk state changed with no walk active.");
`endif

endmodule

`default_nettype wire

// File: dv/ipv6_extension_header_walker_unit_tb.sv
// Self-checking testbench for the IPv6 extension header walker unit.
// Drives header items over the item channel, predicts each result with its own
// walk model and checks it; depends on ehw_pkg, the channel interfaces and the top level.
`timescale 1ns / 1ps

module ipv6_extension_header_walker_unit_tb;
    import ehw_pkg::*;

    localparam int          MAX_CHAIN       = MAX_CHAIN_DEFAULT;
    localparam int          RESET_CYCLES    = 8;
    localparam int          HOLD_OFF_CYCLES = 200;
    localparam int          RANDOM_ITEMS    = 500;
    localparam int          QUIET_ITEMS     = 60;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic                start_req;
        logic [TYPE_W-1:0]   base_next_header;
        logic [L3_W-1:0]     ip_hdr_offset;
        logic                ext_valid;
        logic [TYPE_W-1:0]   ext_next_header;
        logic [7:0]          ext_length;
    } t_walk_item;

    typedef struct packed {
        logic                done_res;
        logic [TYPE_W-1:0]   protocol;
        logic [OFFSET_W-1:0] payload_offset;
        logic [MASK_W-1:0]   eh_mask;
    } t_walk_result;

    logic i_clk;
    logic i_rst_n;

    ehw_item_if   item_if ();
    ehw_result_if result_if ();

    ipv6_extension_header_walker_unit #(
        .MAX_CHAIN(MAX_CHAIN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(result_if)
    );

    // Shadow walk state.
    logic [TYPE_W-1:0]   cur_type;
    logic [OFFSET_W-1:0] run_offset;
    logic [MASK_W-1:0]   seen_mask;
    logic [COUNT_W-1:0]  hdr_count;
    logic                walk_done;

    t_walk_result pending_results[$];
    int unsigned  mismatches;
    int unsigned  cycle_count;
    int unsigned  idle_odds;
    bit           hold_off_req;

    always #1 i_clk = ~i_clk;

    function automatic t_walk_result walk_step(input t_walk_item it);
        logic [MASK_W-1:0]   type_bit;
        logic [OFFSET_W-1:0] hdr_bytes;
        t_walk_result        r;
        if (it.start_req) begin
            cur_type   = it.base_next_header;
            run_offset = OFFSET_W'(it.ip_hdr_offset) + IPV6_FIXED_LEN;
            seen_mask  = '0;
            hdr_count  = '0;
            walk_done  = 1'b0;
        end else if (!walk_done) begin
            case (cur_type)
                T_HOP:      type_bit = 6'b000001;
                T_ROUTING:  type_bit = 6'b000010;
                T_FRAGMENT: type_bit = 6'b000100;
                T_AH:       type_bit = 6'b001000;
                T_DSTOPTS:  type_bit = 6'b010000;
                T_MOBILITY: type_bit = 6'b100000;
                default:    type_bit = '0;
            endcase
            if (!it.ext_valid || type_bit == '0) begin
                walk_done = 1'b1;
            end else begin
                case (cur_type)
                    T_AH:       hdr_bytes = (OFFSET_W'(it.ext_length)
                                            + OFFSET_W'(AH_LEN_BIAS)) << AH_LEN_SHAMT;
                    T_FRAGMENT: hdr_bytes = OFFSET_W'(EH_FRAG_BYTES);
                    default:    hdr_bytes = (OFFSET_W'(it.ext_length)
                                            + OFFSET_W'(OPT_LEN_BIAS)) << OPT_LEN_SHAMT;
                endcase
                seen_mask  = seen_mask | type_bit;
                run_offset = run_offset + hdr_bytes;
                cur_type   = it.ext_next_header;
                hdr_count  = hdr_count + 1'b1;
                if (hdr_count >= MAX_CHAIN) begin
                    walk_done = 1'b1;
                end
            end
        end
        r.done_res       = walk_done;
        r.protocol       = cur_type;
        r.payload_offset = run_offset;
        r.eh_mask        = seen_mask;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Results are checked before the item of the same edge is predicted.
    always @(posedge i_clk) begin
        t_walk_result want;
        t_walk_item   it;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no expected item, actual %h", $time,
                             {result_if.done_res, result_if.protocol,
                              result_if.payload_offset, result_if.eh_mask});
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("done_res", 32'(want.done_res), 32'(result_if.done_res));
                    check_field("protocol", 32'(want.protocol), 32'(result_if.protocol));
                    check_field("payload_offset", 32'(want.payload_offset),
                                32'(result_if.payload_offset));
                    check_field("eh_mask", 32'(want.eh_mask), 32'(result_if.eh_mask));
                end
            end
            if (item_if.valid && item_if.ready) begin
                it.start_req        = item_if.start_req;
                it.base_next_header = item_if.base_next_header;
                it.ip_hdr_offset    = item_if.ip_hdr_offset;
                it.ext_valid        = item_if.ext_valid;
                it.ext_next_header  = item_if.ext_next_header;
                it.ext_length       = item_if.ext_length;
                pending_results.push_back(walk_step(it));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("[ipv6_extension_header_walker_unit] ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        result_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                result_if.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
                result_if.ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                result_if.ready = 1'b1;
            end
        end
    end

    task automatic send_item(input t_walk_item it);
        if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            @(negedge i_clk);
            item_if.valid = 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_if.valid            = 1'b1;
        item_if.start_req        = it.start_req;
        item_if.base_next_header = it.base_next_header;
        item_if.ip_hdr_offset    = it.ip_hdr_offset;
        item_if.ext_valid        = it.ext_valid;
        item_if.ext_next_header  = it.ext_next_header;
        item_if.ext_length       = it.ext_length;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
    endtask

    // Start items carry random header bytes, which the block must ignore.
    task automatic send_start(input logic [TYPE_W-1:0] base, input logic [L3_W-1:0] l3);
        t_walk_item it;
        it.start_req        = 1'b1;
        it.base_next_header = base;
        it.ip_hdr_offset    = l3;
        it.ext_valid        = 1'($urandom);
        it.ext_next_header  = 8'($urandom);
        it.ext_length       = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_header(input logic ext_valid, input logic [TYPE_W-1:0] nxt,
                               input logic [7:0] len);
        t_walk_item it;
        it.start_req        = 1'b0;
        it.base_next_header = 8'($urandom);
        it.ip_hdr_offset    = 12'($urandom);
        it.ext_valid        = ext_valid;
        it.ext_next_header  = nxt;
        it.ext_length       = len;
        send_item(it);
    endtask

    function automatic logic [TYPE_W-1:0] random_ext_type();
        case ($urandom_range(0, 5))
            0:       return T_HOP;
            1:       return T_ROUTING;
            2:       return T_FRAGMENT;
            3:       return T_AH;
            4:       return T_DSTOPTS;
            default: return T_MOBILITY;
        endcase
    endfunction

    function automatic bit is_ext_type(input logic [TYPE_W-1:0] t);
        return t == T_HOP || t == T_ROUTING || t == T_FRAGMENT || t == T_AH
            || t == T_DSTOPTS || t == T_MOBILITY;
    endfunction

    task automatic test_items_before_start();
        send_header(1'b1, T_ROUTING, 8'd255);
        send_header(1'b0, 8'd255, 8'd0);
    endtask

    task automatic test_full_chain_limit();
        send_start(T_HOP, 12'd4095);
        send_header(1'b1, T_ROUTING, 8'd255);
        send_header(1'b1, T_FRAGMENT, 8'd0);
        send_header(1'b1, T_AH, 8'd255);
        send_header(1'b1, T_DSTOPTS, 8'd255);
        send_header(1'b1, T_MOBILITY, 8'd255);
        send_header(1'b1, T_HOP, 8'd255);
        send_header(1'b1, T_ROUTING, 8'd7);
    endtask

    task automatic test_missing_header();
        send_start(T_ROUTING, 12'd0);
        send_header(1'b0, T_HOP, 8'd3);
        send_start(T_FRAGMENT, 12'd100);
        send_header(1'b1, T_AH, 8'd0);
        send_header(1'b0, T_DSTOPTS, 8'd0);
    endtask

    task automatic test_upper_layer_base();
        send_start(8'd6, 12'd20);
        send_header(1'b1, T_HOP, 8'd1);
        send_start(8'd255, 12'd4095);
        send_header(1'b1, 8'd17, 8'd128);
    endtask

    task automatic test_restart_mid_walk();
        send_start(T_AH, 12'd7);
        send_header(1'b1, T_DSTOPTS, 8'd0);
        send_start(T_MOBILITY, 12'd0);
        send_header(1'b1, 8'd17, 8'd1);
        send_header(1'b1, 8'd58, 8'd2);
    endtask

    // The sender keeps offering a whole chain while the result side is held off.
    task automatic test_receiver_hold_off();
        idle_odds    = 0;
        hold_off_req = 1'b1;
        send_start(T_HOP, 12'd14);
        repeat (MAX_CHAIN) send_header(1'b1, random_ext_type(), 8'($urandom));
        repeat (10) send_header(1'b1, 8'($urandom), 8'($urandom));
        while (hold_off_req) @(posedge i_clk);
    endtask

    task automatic test_random_walks();
        int unsigned         sent;
        int unsigned         walks;
        int unsigned         steps;
        logic [TYPE_W-1:0]   cur;
        logic [TYPE_W-1:0]   nxt;
        logic                hdr_ok;
        bit                  ended;
        sent  = 0;
        walks = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
                idle_odds = 0;
            end else if (walks % 8 == 0) begin
                case ($urandom_range(0, 3))
                    0:       idle_odds = 0;
                    1:       idle_odds = 5;
                    2:       idle_odds = 20;
                    default: idle_odds = 50;
                endcase
            end
            walks++;
            cur = ($urandom_range(0, 99) < 85) ? random_ext_type() : 8'($urandom);
            send_start(cur, 12'($urandom));
            sent++;
            steps = 0;
            ended = 0;
            while (!ended) begin
                if ($urandom_range(0, 99) < 4) begin
                    ended = 1;
                end else begin
                    hdr_ok = $urandom_range(0, 99) < 92;
                    nxt    = ($urandom_range(0, 99) < 75) ? random_ext_type() : 8'($urandom);
                    send_header(hdr_ok, nxt, 8'($urandom));
                    sent++;
                    if (!hdr_ok || !is_ext_type(cur)) begin
                        ended = 1;
                    end else begin
                        cur = nxt;
                        steps++;
                        ended = steps >= MAX_CHAIN;
                    end
                end
            end
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 2)) begin
                    send_header(1'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_clk                    = 1'b0;
        i_rst_n                  = 1'b0;
        item_if.valid            = 1'b0;
        item_if.start_req        = 1'b0;
        item_if.base_next_header = '0;
        item_if.ip_hdr_offset    = '0;
        item_if.ext_valid        = 1'b0;
        item_if.ext_next_header  = '0;
        item_if.ext_length       = '0;
        cur_type                 = '0;
        run_offset               = '0;
        seen_mask                = '0;
        hdr_count                = '0;
        walk_done                = 1'b1;
        mismatches               = 0;
        cycle_count              = 0;
        idle_odds                = 20;
        hold_off_req             = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_items_before_start();
        test_full_chain_limit();
        test_missing_header();
        test_upper_layer_base();
        test_restart_mid_walk();
        test_receiver_hold_off();
        test_random_walks();

        @(negedge i_clk);
        item_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ipv6_extension_header_walker_unit] OK");
        end else begin
            $display("[ipv6_extension_header_walker_unit] ERROR");
        end
        $finish;
    end

endmodule
